[hdl/bts_pkg.sv]
package bts_pkg;

    // Default limit on the number of long-form length bytes.
    localparam int unsigned LEN_BYTES_MAX_DEF = 4;

    // Byte masks used while walking tags and lengths.
    localparam logic [7:0] TAG_NUM_MASK  = 8'h1f;
    localparam logic [7:0] MORE_BIT_MASK = 8'h80;
    localparam logic [7:0] LEN_CNT_MASK  = 8'h7f;

    typedef enum logic [2:0] {
        PH_TAG_FIRST = 3'd0,
        PH_TAG_MORE  = 3'd1,
        PH_LEN_FIRST = 3'd2,
        PH_LEN_MORE  = 3'd3,
        PH_VALUE     = 3'd4
    } t_phase;

    // Parse control state that travels between the top level and the step logic.
    typedef struct packed {
        t_phase phase;
        logic   err;
    } t_ctl;

endpackage

[hdl/bts_step.sv]
module bts_step #(
    parameter int unsigned LEN_BYTES_MAX = bts_pkg::LEN_BYTES_MAX_DEF
) (
    input  bts_pkg::t_ctl                          i_ctl,
    input  logic [$clog2(LEN_BYTES_MAX + 1) - 1:0] i_len_left,
    input  logic [8 * LEN_BYTES_MAX - 1:0]         i_val_left,
    input  logic [7:0]                             i_data_byte,
    input  logic                                   i_is_last,
    output bts_pkg::t_ctl                          o_ctl,
    output logic [$clog2(LEN_BYTES_MAX + 1) - 1:0] o_len_left,
    output logic [8 * LEN_BYTES_MAX - 1:0]         o_val_left,
    output logic                                   o_well_formed
);
    import bts_pkg::*;

    localparam int unsigned VW = 8 * LEN_BYTES_MAX;
    localparam int unsigned CW = $clog2(LEN_BYTES_MAX + 1);

    t_ctl          adv_ctl;
    logic [CW-1:0] adv_len;
    logic [VW-1:0] adv_val;
    logic [VW-1:0] shifted_val;
    logic [6:0]    len_cnt;
    logic [CW-1:0] len_dec;

    assign len_cnt     = 7'(i_data_byte & LEN_CNT_MASK);
    assign shifted_val = VW'({i_val_left, i_data_byte});
    assign len_dec     = i_len_left - CW'(1);

    // One byte of the walk, skipped entirely once an error has been seen.
    always_comb begin
        adv_ctl = i_ctl;
        adv_len = i_len_left;
        adv_val = i_val_left;
        if (!i_ctl.err) begin
            case (i_ctl.phase)
                PH_TAG_FIRST: begin
                    adv_ctl.phase = ((i_data_byte & TAG_NUM_MASK) == TAG_NUM_MASK) ?
                                    PH_TAG_MORE : PH_LEN_FIRST;
                end
                PH_TAG_MORE: begin
                    if ((i_data_byte & MORE_BIT_MASK) == 8'h00) begin
                        adv_ctl.phase = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST: begin
                    if ((i_data_byte & MORE_BIT_MASK) != 8'h00) begin
                        if (len_cnt > 7'(LEN_BYTES_MAX)) begin
                            adv_ctl.err = 1'b1;
                        end else if (len_cnt == 7'd0) begin
                            adv_val       = '0;
                            adv_ctl.phase = PH_TAG_FIRST;
                        end else begin
                            adv_len       = len_cnt[CW-1:0];
                            adv_val       = '0;
                            adv_ctl.phase = PH_LEN_MORE;
                        end
                    end else begin
                        adv_val       = VW'(i_data_byte);
                        adv_ctl.phase = (i_data_byte == 8'h00) ? PH_TAG_FIRST : PH_VALUE;
                    end
                end
                PH_LEN_MORE: begin
                    adv_val = shifted_val;
                    if (i_len_left != '0) begin
                        adv_len = len_dec;
                    end
                    if (i_len_left <= CW'(1)) begin
                        adv_ctl.phase = (shifted_val == '0) ? PH_TAG_FIRST : PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (i_val_left != '0) begin
                        adv_val = i_val_left - VW'(1);
                    end
                    if (i_val_left <= VW'(1)) begin
                        adv_ctl.phase = PH_TAG_FIRST;
                    end
                end
                default: begin
                    adv_ctl.phase = PH_TAG_FIRST;
                end
            endcase
        end
    end

    // The last byte of a buffer reports and returns the walk to its start.
    always_comb begin
        o_well_formed = !adv_ctl.err && (adv_ctl.phase == PH_TAG_FIRST);
        if (i_is_last) begin
            o_ctl.phase = PH_TAG_FIRST;
            o_ctl.err   = 1'b0;
            o_len_left  = '0;
            o_val_left  = '0;
        end else begin
            o_ctl      = adv_ctl;
            o_len_left = adv_len;
            o_val_left = adv_val;
        end
    end

endmodule

[hdl/ber_tlv_structure_checker_unit.sv]
// A byte transferred into the input register is held there and, when it is the last byte
// of a buffer, its result is loaded into the result register, which drives o_valid.
// Throughput: one byte per cycle; the combinational step logic between the input register and
// the result register sets that figure. A result still waiting holds a last byte in the
// input register, and with it the input, until the result is transferred.
// Reset: i_rst_n is synchronous and active low; it empties both registers and returns the
// parser to the expect-first-tag-byte state with no error and zero counters.
module ber_tlv_structure_checker_unit #(
    parameter int unsigned LEN_BYTES_MAX = bts_pkg::LEN_BYTES_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_well_formed
);
    import bts_pkg::*;

    localparam int unsigned VW = 8 * LEN_BYTES_MAX;
    localparam int unsigned CW = $clog2(LEN_BYTES_MAX + 1);

    // Input register: one byte and its end-of-buffer mark.
    logic          r_in_valid;
    logic [7:0]    r_data_byte;
    logic          r_is_last;

    // Parser state, updated as each byte leaves the input register.
    t_ctl          r_ctl;
    logic [CW-1:0] r_len_left;
    logic [VW-1:0] r_val_left;

    // Result register.
    logic          r_out_valid;
    logic          r_well_formed;

    t_ctl          n_ctl;
    logic [CW-1:0] n_len_left;
    logic [VW-1:0] n_val_left;
    logic          n_well_formed;

    logic          out_free;
    logic          advance;
    logic          in_xfer;

    bts_step #(
        .LEN_BYTES_MAX(LEN_BYTES_MAX)
    ) u_step (
        .i_ctl        (r_ctl),
        .i_len_left   (r_len_left),
        .i_val_left   (r_val_left),
        .i_data_byte  (r_data_byte),
        .i_is_last    (r_is_last),
        .o_ctl        (n_ctl),
        .o_len_left   (n_len_left),
        .o_val_left   (n_val_left),
        .o_well_formed(n_well_formed)
    );

    // A byte that is not the last one never needs the result slot, so it always moves on.
    // The last byte waits only when a previous result is still unclaimed.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!r_is_last || out_free);
    assign o_ready  = !r_in_valid || advance;
    assign in_xfer  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_data_byte <= i_data_byte;
            r_is_last   <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase <= PH_TAG_FIRST;
            r_ctl.err   <= 1'b0;
            r_len_left  <= '0;
            r_val_left  <= '0;
        end else if (advance) begin
            r_ctl      <= n_ctl;
            r_len_left <= n_len_left;
            r_val_left <= n_val_left;
        end
    end

    // The result slot loads on the last byte of a buffer and empties on an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_is_last) begin
            r_well_formed <= n_well_formed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_well_formed = r_well_formed;

endmodule
